// ===== design/ptc_pkg.sv =====
// shared types, constants, coefficient unpacking and microprogram of the compensation unit
package ptc_pkg;

  localparam int FRAC_BITS_DEF = 6;   // default output fraction bits
  localparam int Q_FRAC        = 30;  // fraction bits of scaled values and partial sums
  localparam int RAW_W         = 24;
  localparam int VAL_W         = 32;  // scaled values and results
  localparam int COEF_W        = 20;  // widest coefficient
  localparam int ACC_W         = 56;  // partial sums stay below 2^52
  localparam int MA_W          = 33;  // multiplier operand a, signed
  localparam int MB_W          = 32;  // multiplier operand b, signed
  localparam int PROD_W        = MA_W + MB_W;
  localparam int PROG_LEN      = 17;
  localparam int PC_W          = $clog2(PROG_LEN);
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CALIB_LOW      = 3'd0,
    REG_CALIB_MID      = 3'd1,
    REG_CALIB_TOP      = 3'd2,
    REG_TEMP_SCALE     = 3'd3,
    REG_PRESSURE_SCALE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] calib_low;
    logic [63:0] calib_mid;
    logic [15:0] calib_top;
    logic [31:0] temp_scale;
    logic [31:0] pressure_scale;
  } calib_t;

  // multiplier operand a
  typedef enum logic [1:0] {
    MA_SCALE,   // scale register picked by the item kind, unsigned
    MA_COEF,    // coefficient
    MA_HI,      // partial sum shifted down by the fraction bits
    MA_LO       // fraction bits of a partial sum, unsigned
  } mul_a_t;

  // multiplier operand b
  typedef enum logic [1:0] {
    MB_RAW,
    MB_S,       // scaled value of this item
    MB_T        // last stored scaled temperature
  } mul_b_t;

  typedef enum logic {
    SRC_X,
    SRC_Y
  } src_t;

  typedef enum logic [3:0] {
    C_0, C_1, C_00, C_10, C_01, C_11, C_20, C_21, C_30
  } coef_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SCALE,      // s = clip(prod >>> 2)
    OP_COEF_PROD,  // dst = coef term + prod
    OP_ADD_PROD,   // dst += prod
    OP_ADD_PSHR,   // dst += prod >>> 30
    OP_FINISH      // round, clip and hand to the output register
  } op_t;

  typedef enum logic [1:0] {
    DST_X,
    DST_Y,
    DST_ACC
  } dst_t;

  typedef enum logic {
    JMP_NEXT,
    JMP_IF_PRESS
  } jump_t;

  typedef struct packed {
    mul_a_t            ma;
    mul_b_t            mb;
    src_t              msrc;
    coef_t             mcoef;
    op_t               op;
    dst_t              dst;
    coef_t             acoef;
    jump_t             jmp;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  typedef struct packed {
    logic press;   // item in work is a pressure reading
    logic stall;   // output register full and not taken
  } dp_status_t;

  localparam ctrl_t CTRL_NOP = '{
    ma: MA_COEF, mb: MB_S, msrc: SRC_X, mcoef: C_0, op: OP_NONE,
    dst: DST_ACC, acoef: C_0, jmp: JMP_NEXT, target: '0
  };

  localparam logic [PC_W-1:0] PC_PRESS = PC_W'(5);

  // coefficient fields, byte 0 in the top bits of the low word
  function automatic logic signed [COEF_W-1:0] coef_value(input coef_t sel, input calib_t cal);
    logic signed [COEF_W-1:0] v;
    begin
      case (sel)
        C_0:     v = COEF_W'($signed(cal.calib_low[63:52]));
        C_1:     v = COEF_W'($signed(cal.calib_low[51:40]));
        C_00:    v = COEF_W'($signed(cal.calib_low[39:20]));
        C_10:    v = COEF_W'($signed(cal.calib_low[19:0]));
        C_01:    v = COEF_W'($signed(cal.calib_mid[63:48]));
        C_11:    v = COEF_W'($signed(cal.calib_mid[47:32]));
        C_20:    v = COEF_W'($signed(cal.calib_mid[31:16]));
        C_21:    v = COEF_W'($signed(cal.calib_mid[15:0]));
        C_30:    v = COEF_W'($signed(cal.calib_top[15:0]));
        default: v = '0;
      endcase
      coef_value = v;
    end
  endfunction

  // microprogram: temperature path ends at step 4, pressure path runs 5 to 16
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    begin
      w = CTRL_NOP;
      case (pc)
        PC_W'(0): begin
          w.ma = MA_SCALE; w.mb = MB_RAW;
        end
        PC_W'(1): begin
          w.op = OP_SCALE; w.jmp = JMP_IF_PRESS; w.target = PC_PRESS;
        end
        PC_W'(2): begin
          w.ma = MA_COEF; w.mcoef = C_1; w.mb = MB_S;
        end
        PC_W'(3): begin
          w.op = OP_COEF_PROD; w.dst = DST_ACC; w.acoef = C_0;
        end
        PC_W'(4): begin
          w.op = OP_FINISH;
        end
        PC_W'(5): begin
          w.ma = MA_COEF; w.mcoef = C_30; w.mb = MB_S;
        end
        PC_W'(6): begin
          w.op = OP_COEF_PROD; w.dst = DST_X; w.acoef = C_20;
          w.ma = MA_COEF; w.mcoef = C_21; w.mb = MB_S;
        end
        PC_W'(7): begin
          w.op = OP_COEF_PROD; w.dst = DST_Y; w.acoef = C_11;
          w.ma = MA_HI; w.msrc = SRC_X; w.mb = MB_S;
        end
        PC_W'(8): begin
          w.ma = MA_LO; w.msrc = SRC_X; w.mb = MB_S;
          w.op = OP_COEF_PROD; w.dst = DST_X; w.acoef = C_10;
        end
        PC_W'(9): begin
          w.op = OP_ADD_PSHR; w.dst = DST_X;
          w.ma = MA_HI; w.msrc = SRC_Y; w.mb = MB_S;
        end
        PC_W'(10): begin
          w.ma = MA_LO; w.msrc = SRC_Y; w.mb = MB_S;
          w.op = OP_COEF_PROD; w.dst = DST_Y; w.acoef = C_01;
        end
        PC_W'(11): begin
          w.op = OP_ADD_PSHR; w.dst = DST_Y;
          w.ma = MA_HI; w.msrc = SRC_X; w.mb = MB_S;
        end
        PC_W'(12): begin
          w.ma = MA_LO; w.msrc = SRC_X; w.mb = MB_S;
          w.op = OP_COEF_PROD; w.dst = DST_ACC; w.acoef = C_00;
        end
        PC_W'(13): begin
          w.op = OP_ADD_PSHR; w.dst = DST_ACC;
          w.ma = MA_HI; w.msrc = SRC_Y; w.mb = MB_T;
        end
        PC_W'(14): begin
          w.ma = MA_LO; w.msrc = SRC_Y; w.mb = MB_T;
          w.op = OP_ADD_PROD; w.dst = DST_ACC;
        end
        PC_W'(15): begin
          w.op = OP_ADD_PSHR; w.dst = DST_ACC;
        end
        PC_W'(16): begin
          w.op = OP_FINISH;
        end
        default: w = CTRL_NOP;
      endcase
      ucode = w;
    end
  endfunction

endpackage

// ===== design/pressure_temperature_compensation_unit.sv =====
// top level of the barometric sensor compensation unit
//
// usage
// - slave stream: one word per raw reading; tdata is the signed 24-bit
//   converter value, tuser says temperature (0) or pressure (1)
// - master stream: one word per reading; tdata is the compensated value
//   with FRAC_BITS fraction bits, tuser carries the kind and a clip flag
// - configuration: cfg_we writes cfg_data to register cfg_index at the
//   clock edge; calibration words 0..2, temperature scale 3, pressure
//   scale 4; other indexes are ignored; write only while idle
// - sequencing: one shared 33x32 multiplier stepped by a 17-entry microprogram;
//   a pressure word takes a longer path through it than a temperature word;
//   s_tready is low while a word is in work
// - the result is registered into the output register at the end of the last step;
//   the next word is accepted while that result waits
// - if the receiver stalls with a result still held, the sequencer waits
//   on its last step until the output register frees up
// - reset (synchronous) clears the calibration to zero, both scales to
//   8192, the stored temperature to zero and drops any word in work
module pressure_temperature_compensation_unit
  import ptc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // raw_reading
  input  logic [0:0]            s_tuser,   // cmd
  // master stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // compensated_value
  output logic [1:0]            m_tuser,   // value_kind, saturated
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  calib_t     cal;
  ctrl_t      ctrl;
  dp_status_t status;
  logic       busy;
  logic       start;
  logic       out_kind;
  logic       out_sat;

  assign s_tready = !busy;
  assign start    = s_tvalid && s_tready;
  assign m_tuser  = {out_sat, out_kind};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal.calib_low      <= '0;
      cal.calib_mid      <= '0;
      cal.calib_top      <= '0;
      cal.temp_scale     <= 32'd8192;
      cal.pressure_scale <= 32'd8192;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CALIB_LOW:      cal.calib_low      <= cfg_data;
        REG_CALIB_MID:      cal.calib_mid      <= cfg_data;
        REG_CALIB_TOP:      cal.calib_top      <= cfg_data[15:0];
        REG_TEMP_SCALE:     cal.temp_scale     <= cfg_data[31:0];
        REG_PRESSURE_SCALE: cal.pressure_scale <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // step counter and microprogram
  ptc_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  // multiplier, partial sums and output register
  ptc_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_cmd    (s_tuser[0]),
    .in_raw    ($signed(s_tdata)),
    .cal       (cal),
    .ctrl      (ctrl),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_value (m_tdata),
    .out_kind  (out_kind),
    .out_sat   (out_sat)
  );

endmodule

// ===== design/ptc_sequencer.sv =====
// step counter and microprogram fetch of the compensation unit
module ptc_sequencer
  import ptc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output ctrl_t      ctrl
);

  logic [PC_W-1:0] pc;
  ctrl_t           word;

  assign word = ucode(pc);
  assign ctrl = busy ? word : CTRL_NOP;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        pc   <= '0;
      end
    end else if (word.op == OP_FINISH) begin
      // hold on the last step until the output register is free
      if (!status.stall) begin
        busy <= 1'b0;
      end
    end else if (word.jmp == JMP_IF_PRESS && status.press) begin
      pc <= word.target;
    end else begin
      pc <= pc + PC_W'(1);
    end
  end

endmodule

// ===== design/ptc_datapath.sv =====
// shared multiplier, partial-sum registers, rounding and output register
module ptc_datapath
  import ptc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    in_cmd,
  input  logic signed [RAW_W-1:0] in_raw,
  input  calib_t                  cal,
  input  ctrl_t                   ctrl,
  output dp_status_t              status,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [VAL_W-1:0]        out_value,
  output logic                    out_kind,
  output logic                    out_sat
);

  localparam int SH = Q_FRAC - FRAC_BITS;
  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(1) <<< (SH - 1);

  logic                     cmd_r;
  logic signed [RAW_W-1:0]  raw_r;
  logic                     sat_r;
  logic signed [VAL_W-1:0]  s;
  logic signed [VAL_W-1:0]  last_temp;
  logic signed [ACC_W-1:0]  x, y, acc;
  logic signed [PROD_W-1:0] prod;

  logic signed [ACC_W-1:0]  x_sel, hi_full, dst_val, term, alu;
  logic signed [MA_W-1:0]   ma_val;
  logic signed [MB_W-1:0]   mb_val;
  logic signed [COEF_W-1:0] mcoef, acoef;
  logic [31:0]              scale_sel;
  logic signed [PROD_W-1:0] sv, pshr;
  logic                     sv_fit;
  logic signed [VAL_W-1:0]  scaled;
  logic signed [ACC_W:0]    rnd, r;
  logic                     r_fit;
  logic signed [VAL_W-1:0]  result;
  logic                     stall;

  assign stall        = out_valid && !out_ready;
  assign status.stall = stall;
  assign status.press = cmd_r;

  // multiplier operands
  assign x_sel     = (ctrl.msrc == SRC_X) ? x : y;
  assign hi_full   = x_sel >>> Q_FRAC;
  assign mcoef     = coef_value(ctrl.mcoef, cal);
  assign scale_sel = cmd_r ? cal.pressure_scale : cal.temp_scale;

  always_comb begin
    case (ctrl.ma)
      MA_SCALE: ma_val = $signed({1'b0, scale_sel});
      MA_COEF:  ma_val = MA_W'(mcoef);
      MA_HI:    ma_val = MA_W'(hi_full);
      MA_LO:    ma_val = $signed({{(MA_W - Q_FRAC){1'b0}}, x_sel[Q_FRAC-1:0]});
      default:  ma_val = '0;
    endcase
    case (ctrl.mb)
      MB_RAW:  mb_val = MB_W'(raw_r);
      MB_S:    mb_val = MB_W'(s);
      MB_T:    mb_val = MB_W'(last_temp);
      default: mb_val = '0;
    endcase
  end

  // scaled value: drop two fraction bits, clip to q2.30
  assign sv     = prod >>> 2;
  assign sv_fit = (&sv[PROD_W-1:VAL_W-1]) || !(|sv[PROD_W-1:VAL_W-1]);
  assign scaled = sv_fit ? sv[VAL_W-1:0] : (sv[PROD_W-1] ? VAL_MIN : VAL_MAX);

  // accumulate; c0 only ever enters as c0/2, so it is shifted one less
  assign acoef = coef_value(ctrl.acoef, cal);
  assign term  = (ctrl.acoef == C_0) ? (ACC_W'(acoef) <<< (Q_FRAC - 1))
                                     : (ACC_W'(acoef) <<< Q_FRAC);
  assign pshr  = prod >>> Q_FRAC;

  always_comb begin
    case (ctrl.dst)
      DST_X:   dst_val = x;
      DST_Y:   dst_val = y;
      DST_ACC: dst_val = acc;
      default: dst_val = acc;
    endcase
    case (ctrl.op)
      OP_COEF_PROD: alu = term + prod[ACC_W-1:0];
      OP_ADD_PROD:  alu = dst_val + prod[ACC_W-1:0];
      OP_ADD_PSHR:  alu = dst_val + pshr[ACC_W-1:0];
      default:      alu = dst_val;
    endcase
  end

  // final value: round half up, clip to 32 bits
  assign rnd    = (ACC_W + 1)'(acc) + RND_HALF;
  assign r      = rnd >>> SH;
  assign r_fit  = (&r[ACC_W:VAL_W-1]) || !(|r[ACC_W:VAL_W-1]);
  assign result = r_fit ? r[VAL_W-1:0] : (r[ACC_W] ? VAL_MIN : VAL_MAX);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(ma_val) * PROD_W'(mb_val);
    if (start) begin
      cmd_r <= in_cmd;
      raw_r <= in_raw;
      sat_r <= 1'b0;
    end
    if (ctrl.op == OP_SCALE) begin
      s <= scaled;
      if (!sv_fit) begin
        sat_r <= 1'b1;
      end
    end
    if (ctrl.op == OP_COEF_PROD || ctrl.op == OP_ADD_PROD || ctrl.op == OP_ADD_PSHR) begin
      case (ctrl.dst)
        DST_X:   x <= alu;
        DST_Y:   y <= alu;
        DST_ACC: acc <= alu;
        default: acc <= alu;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_temp <= '0;
    end else if (ctrl.op == OP_SCALE && !cmd_r) begin
      last_temp <= scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_FINISH && !stall) begin
      out_valid <= 1'b1;
      out_value <= result;
      out_kind  <= cmd_r;
      out_sat   <= sat_r | !r_fit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
